[rtl/core/hrp_pkg.sv]
package hrp_pkg;

    typedef enum logic [2:0]
    {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADERS = 3'd3,
        PH_BODY    = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [1:0]
    {
        MK_HIT  = 2'd0,
        MK_NONE = 2'd1,
        MK_WAIT = 2'd2,
        MK_BAD  = 2'd3
    } mkind_t;

    localparam logic [2:0] SS_ZERO    = 3'd0;
    localparam logic [2:0] US_PATH    = 3'd1;
    localparam logic [2:0] US_KEY     = 3'd2;
    localparam logic [2:0] US_VAL     = 3'd3;
    localparam logic [2:0] HS_LEAD_NL = 3'd1;
    localparam logic [2:0] HS_KEY     = 3'd2;
    localparam logic [2:0] HS_VLEAD   = 3'd3;
    localparam logic [2:0] HS_VAL     = 3'd4;
    localparam logic [2:0] HS_END     = 3'd5;

    localparam logic [3:0] BC_SKIP    = 4'd0;
    localparam logic [3:0] BC_METHOD  = 4'd1;
    localparam logic [3:0] BC_PATH    = 4'd2;
    localparam logic [3:0] BC_QKEY    = 4'd3;
    localparam logic [3:0] BC_QVAL    = 4'd4;
    localparam logic [3:0] BC_VERSION = 4'd5;
    localparam logic [3:0] BC_HKEY    = 4'd6;
    localparam logic [3:0] BC_HVAL    = 4'd7;
    localparam logic [3:0] BC_BARE    = 4'd8;
    localparam logic [3:0] BC_DELIM   = 4'd9;
    localparam logic [3:0] BC_BODY    = 4'd10;

    localparam logic [1:0] KA_NONE  = 2'd0;
    localparam logic [1:0] KA_FALSE = 2'd1;
    localparam logic [1:0] KA_TRUE  = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_METHOD  = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;

    localparam logic [1:0] VER_09 = 2'd1;
    localparam logic [1:0] VER_10 = 2'd2;
    localparam logic [1:0] VER_11 = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUERY = 8'h3f;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_K  = 8'h6b;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;

    localparam logic [4:0] KEY_LEN_CONTENT_LENGTH = 5'd14;
    localparam logic [4:0] KEY_LEN_CONNECTION     = 5'd10;
    localparam logic [3:0] VERSION_DIGIT_POS      = 4'd7;
    localparam int         NUM_TESTS              = 27;
    localparam int         METHOD_PEEK_DEPTH      = 5;

    localparam logic [7:0] MT_FIRST [NUM_TESTS] = '{
        "C", "C", "C", "D", "G", "H", "L", "M", "M", "M", "M", "M", "M", "N",
        "O", "P", "P", "P", "P", "P", "P", "R", "S", "S", "T", "U", "U"};
    localparam logic [2:0] MT_IDX [NUM_TESTS] = '{
        3'd2, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd2, 3'd3, 3'd1, 3'd1,
        3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd4, 3'd0, 3'd1, 3'd1,
        3'd0, 3'd2, 3'd2};
    localparam logic [7:0] MT_CH [NUM_TESTS] = '{
        "N", "E", "P", "D", "G", "H", "L", "O", "A", "A", "-", "E", "O", "N",
        "O", "O", "U", "A", "R", "F", "P", "R", "U", "E", "T", "L", "S"};
    localparam logic [3:0] MLEN [32] = '{
        4'd0, 4'd7, 4'd8, 4'd4, 4'd6, 4'd3, 4'd4, 4'd4, 4'd5, 4'd10, 4'd10,
        4'd8, 4'd5, 4'd4, 4'd6, 4'd7, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd9,
        4'd6, 4'd9, 4'd6, 4'd5, 4'd6, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0};

    typedef logic [METHOD_PEEK_DEPTH-1:0][7:0] peek_t;

    typedef struct packed
    {
        mkind_t     kind;
        logic [4:0] code;
    } mclass_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic [7:0] lower;
        logic       blank;
        logic       is_digit;
        logic [3:0] digit;
        logic       start;
    } tok_t;

    typedef struct packed
    {
        logic [3:0]  byte_class;
        logic [7:0]  out_byte;
        logic        field_end;
        logic [2:0]  phase;
        logic [4:0]  method_code;
        logic [1:0]  version_code;
        logic [31:0] content_length;
        logic [1:0]  keep_alive;
        logic        tls_requested;
        logic        upgrade_requested;
        logic        expect_seen;
        logic [1:0]  error_code;
    } res_t;

    function automatic mclass_t classify(input peek_t m, input logic [3:0] p);
        mclass_t r;
        logic    known;
        logic    done;
        r.kind = MK_BAD;
        r.code = '0;
        known  = 1'b0;
        done   = 1'b0;
        for (int i = 0; i < NUM_TESTS; i++)
        begin
            if (!done && MT_FIRST[i] == m[0])
            begin
                known = 1'b1;
                if ({1'b0, MT_IDX[i]} > p)
                begin
                    r.kind = MK_WAIT;
                    done   = 1'b1;
                end
                else if (m[MT_IDX[i]] == MT_CH[i])
                begin
                    r.kind = MK_HIT;
                    r.code = 5'(i + 1);
                    done   = 1'b1;
                end
            end
        end
        if (!done)
        begin
            r.kind = known ? MK_NONE : MK_BAD;
        end
        return r;
    endfunction

endpackage

[rtl/core/hrp_if.sv]
interface hrp_req_if import hrp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_request;

    modport source (output valid, data_byte, start_request, input ready);
    modport sink (input valid, data_byte, start_request, output ready);
endinterface

interface hrp_res_if import hrp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [3:0]  byte_class;
    logic [7:0]  out_byte;
    logic        field_end;
    logic [2:0]  phase;
    logic [4:0]  method_code;
    logic [1:0]  version_code;
    logic [31:0] content_length;
    logic [1:0]  keep_alive;
    logic        tls_requested;
    logic        upgrade_requested;
    logic        expect_seen;
    logic [1:0]  error_code;

    modport source (output valid, byte_class, out_byte, field_end, phase, method_code,
                    version_code, content_length, keep_alive, tls_requested,
                    upgrade_requested, expect_seen, error_code, input ready);
    modport sink (input valid, byte_class, out_byte, field_end, phase, method_code,
                  version_code, content_length, keep_alive, tls_requested,
                  upgrade_requested, expect_seen, error_code, output ready);
endinterface

[rtl/core/hrp_front.sv]
module hrp_front import hrp_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       start_request,
    output tok_t       tok
);

    always_comb
    begin
        tok.data     = data_byte;
        tok.start    = start_request;
        tok.lower    = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
        tok.blank    = (data_byte == CH_SP) || (data_byte == CH_CR) || (data_byte == CH_LF);
        tok.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
        tok.digit    = 4'(data_byte - CH_ZERO);
    end

endmodule

[rtl/core/hrp_queue.sv]
module hrp_queue import hrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output tok_t pop_data
);

    tok_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/core/hrp_back.sv]
module hrp_back import hrp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic tok_valid,
    input  tok_t tok,
    output logic tok_pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int PW = $clog2(METHOD_PEEK_DEPTH);

    phase_t                 phase_reg, phase_next;
    logic [2:0]             sub_reg, sub_next;
    logic [3:0]             pos_reg, pos_next;
    logic [4:0]             meth_reg, meth_next;
    logic [1:0]             ver_reg, ver_next;
    logic [7:0]             kfc_reg, kfc_next;
    logic [4:0]             klen_reg, klen_next;
    logic [7:0]             vfc_reg, vfc_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [1:0]             ka_reg, ka_next;
    logic [1:0]             err_reg, err_next;
    logic                   tls_reg, tls_next;
    logic                   upg_reg, upg_next;
    logic                   exp_reg, exp_next;
    logic [7:0]             prev_reg;
    logic [7:0]             pfx_reg [METHOD_PEEK_DEPTH];
    logic                   pfx_we;
    logic                   out_valid_reg;
    res_t                   out_reg, out_next;

    phase_t                 c_ph;
    logic [2:0]             c_sub;
    logic [3:0]             c_pos;
    logic [4:0]             c_meth;
    logic [1:0]             c_ver;
    logic [7:0]             c_kfc;
    logic [4:0]             c_klen;
    logic [7:0]             c_vfc;
    logic [LENGTH_BITS-1:0] c_acc;
    logic [LENGTH_BITS-1:0] c_len;
    logic [1:0]             c_ka;
    logic [1:0]             c_err;
    logic                   c_tls;
    logic                   c_upg;
    logic                   c_exp;
    logic [7:0]             c_prev;

    logic [3:0]             cls;
    logic                   fe;
    logic [7:0]             ob;
    logic [7:0]             b;
    peek_t                  peek;
    mclass_t                mc;
    logic [LENGTH_BITS+3:0] acc_wide;

    assign tok_pop   = tok_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign b         = tok.data;
    assign acc_wide  = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0}
                     + (LENGTH_BITS + 4)'(tok.digit);

    always_comb
    begin
        c_ph   = tok.start ? PH_METHOD : phase_reg;
        c_sub  = tok.start ? SS_ZERO : sub_reg;
        c_pos  = tok.start ? 4'd0 : pos_reg;
        c_meth = tok.start ? 5'd0 : meth_reg;
        c_ver  = tok.start ? 2'd0 : ver_reg;
        c_kfc  = tok.start ? 8'd0 : kfc_reg;
        c_klen = tok.start ? 5'd0 : klen_reg;
        c_vfc  = tok.start ? 8'd0 : vfc_reg;
        c_acc  = tok.start ? '0 : acc_reg;
        c_len  = tok.start ? '0 : len_reg;
        c_ka   = tok.start ? KA_NONE : ka_reg;
        c_err  = tok.start ? ERR_NONE : err_reg;
        c_tls  = tok.start ? 1'b0 : tls_reg;
        c_upg  = tok.start ? 1'b0 : upg_reg;
        c_exp  = tok.start ? 1'b0 : exp_reg;
        c_prev = tok.start ? 8'd0 : prev_reg;
        for (int i = 0; i < METHOD_PEEK_DEPTH; i++)
        begin
            peek[i] = (c_pos == 4'(i)) ? b : pfx_reg[i];
        end
    end

    assign mc = classify(peek, c_pos);

    always_comb
    begin
        logic [4:0] mcode;
        logic       do_len;
        logic       start_line;
        logic       do_key;
        logic       do_val;
        logic       commit;
        logic       end_head;
        logic [4:0] kl_in;
        logic       go;
        phase_t     go_ph;

        phase_next = c_ph;
        sub_next   = c_sub;
        pos_next   = c_pos;
        meth_next  = c_meth;
        ver_next   = c_ver;
        kfc_next   = c_kfc;
        klen_next  = c_klen;
        vfc_next   = c_vfc;
        acc_next   = c_acc;
        len_next   = c_len;
        ka_next    = c_ka;
        err_next   = c_err;
        tls_next   = c_tls;
        upg_next   = c_upg;
        exp_next   = c_exp;
        pfx_we     = 1'b0;
        cls        = BC_SKIP;
        fe         = 1'b0;
        ob         = b;
        mcode      = c_meth;
        do_len     = 1'b0;
        start_line = 1'b0;
        do_key     = 1'b0;
        do_val     = 1'b0;
        commit     = 1'b0;
        end_head   = 1'b0;
        kl_in      = c_klen;
        go         = 1'b0;
        go_ph      = c_ph;

        unique case (c_ph)
            PH_METHOD:
            begin
                cls = BC_METHOD;
                if (c_meth == 5'd0)
                begin
                    pfx_we = ({1'b0, c_pos} < 5'(METHOD_PEEK_DEPTH));
                    unique case (mc.kind)
                        MK_BAD:
                        begin
                            err_next = ERR_METHOD;
                            go       = 1'b1;
                            go_ph    = PH_DONE;
                            fe       = 1'b1;
                        end
                        MK_NONE:
                        begin
                            go    = 1'b1;
                            go_ph = PH_URI;
                            fe    = 1'b1;
                        end
                        MK_WAIT:
                        begin
                            if (c_pos != 4'd15)
                            begin
                                pos_next = c_pos + 4'd1;
                            end
                        end
                        default:
                        begin
                            meth_next = mc.code;
                            mcode     = mc.code;
                            do_len    = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    do_len = 1'b1;
                end
                if (do_len)
                begin
                    if ({1'b0, c_pos} + 5'd1 >= {1'b0, MLEN[mcode]})
                    begin
                        go    = 1'b1;
                        go_ph = PH_URI;
                        fe    = 1'b1;
                    end
                    else if (c_pos != 4'd15)
                    begin
                        pos_next = c_pos + 4'd1;
                    end
                end
            end
            PH_URI:
            begin
                if (c_sub == SS_ZERO && tok.blank)
                begin
                    cls = BC_SKIP;
                end
                else
                begin
                    sub_next = (c_sub == SS_ZERO) ? US_PATH : c_sub;
                    if (b == CH_SP)
                    begin
                        go    = 1'b1;
                        go_ph = PH_VERSION;
                        fe    = 1'b1;
                        cls   = BC_DELIM;
                    end
                    else if (b == CH_QUERY && sub_next <= US_VAL)
                    begin
                        sub_next = US_KEY;
                        fe       = 1'b1;
                        cls      = BC_DELIM;
                    end
                    else if (sub_next == US_PATH)
                    begin
                        cls = BC_PATH;
                    end
                    else if (b == CH_AMP)
                    begin
                        sub_next = US_KEY;
                        fe       = 1'b1;
                        cls      = BC_DELIM;
                    end
                    else if (sub_next == US_KEY)
                    begin
                        if (b == CH_EQ)
                        begin
                            sub_next = US_VAL;
                            fe       = 1'b1;
                            cls      = BC_DELIM;
                        end
                        else
                        begin
                            cls = BC_QKEY;
                        end
                    end
                    else
                    begin
                        cls = BC_QVAL;
                    end
                end
            end
            PH_VERSION:
            begin
                if (c_sub == SS_ZERO && tok.blank)
                begin
                    cls = BC_SKIP;
                end
                else
                begin
                    sub_next = US_PATH;
                    cls      = BC_VERSION;
                    if (c_pos < VERSION_DIGIT_POS)
                    begin
                        pos_next = c_pos + 4'd1;
                    end
                    else
                    begin
                        fe = 1'b1;
                        go = 1'b1;
                        if (b == CH_ONE)
                        begin
                            ver_next = VER_11;
                            go_ph    = PH_HEADERS;
                        end
                        else if (b == CH_ZERO)
                        begin
                            ver_next = VER_10;
                            ka_next  = KA_FALSE;
                            go_ph    = PH_HEADERS;
                        end
                        else if (b == CH_NINE)
                        begin
                            ver_next = VER_09;
                            ka_next  = KA_FALSE;
                            go_ph    = PH_HEADERS;
                        end
                        else
                        begin
                            err_next = ERR_VERSION;
                            go_ph    = PH_DONE;
                        end
                    end
                end
            end
            PH_HEADERS:
            begin
                case (c_sub)
                    HS_LEAD_NL:
                    begin
                        if (b == CH_SP)
                        begin
                            cls = BC_SKIP;
                        end
                        else if (b == CH_LF)
                        begin
                            end_head = 1'b1;
                        end
                        else if (b == CH_CR)
                        begin
                            sub_next = HS_END;
                            cls      = BC_DELIM;
                        end
                        else
                        begin
                            start_line = 1'b1;
                        end
                    end
                    HS_END:
                    begin
                        end_head = 1'b1;
                    end
                    HS_KEY, HS_VAL:
                    begin
                        if (c_prev == CH_LF && b != CH_SP)
                        begin
                            commit = (c_sub == HS_VAL);
                            fe     = 1'b1;
                            if (b == CH_LF)
                            begin
                                end_head = 1'b1;
                            end
                            else if (b == CH_CR)
                            begin
                                sub_next = HS_END;
                                cls      = BC_DELIM;
                            end
                            else
                            begin
                                start_line = 1'b1;
                            end
                        end
                        else if (c_sub == HS_KEY)
                        begin
                            do_key = 1'b1;
                        end
                        else
                        begin
                            do_val = 1'b1;
                        end
                    end
                    HS_VLEAD:
                    begin
                        if (tok.blank)
                        begin
                            cls = BC_SKIP;
                        end
                        else
                        begin
                            vfc_next = b;
                            sub_next = HS_VAL;
                            do_val   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (b == CH_SP)
                        begin
                            cls = BC_SKIP;
                        end
                        else if (b == CH_CR)
                        begin
                            cls = BC_DELIM;
                        end
                        else if (b == CH_LF)
                        begin
                            sub_next = HS_LEAD_NL;
                            cls      = BC_DELIM;
                        end
                        else
                        begin
                            start_line = 1'b1;
                        end
                    end
                endcase

                if (start_line)
                begin
                    kl_in     = 5'd0;
                    klen_next = 5'd0;
                    kfc_next  = 8'd0;
                    sub_next  = HS_KEY;
                    do_key    = 1'b1;
                end
                if (do_key)
                begin
                    if (b == CH_LF)
                    begin
                        cls = BC_BARE;
                    end
                    else if (b == CH_CR)
                    begin
                        cls = BC_DELIM;
                    end
                    else if (b == CH_COLON)
                    begin
                        fe       = 1'b1;
                        sub_next = HS_VLEAD;
                        vfc_next = 8'd0;
                        acc_next = '0;
                        cls      = BC_DELIM;
                    end
                    else
                    begin
                        ob  = tok.lower;
                        cls = BC_HKEY;
                        if (kl_in == 5'd0)
                        begin
                            kfc_next = tok.lower;
                        end
                        if (kl_in != 5'd31)
                        begin
                            klen_next = kl_in + 5'd1;
                        end
                    end
                end
                if (do_val)
                begin
                    if (b == CH_LF || b == CH_CR)
                    begin
                        cls = BC_DELIM;
                    end
                    else
                    begin
                        cls = BC_HVAL;
                        if (tok.is_digit)
                        begin
                            acc_next = (acc_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                     ? '1 : acc_wide[LENGTH_BITS-1:0];
                        end
                    end
                end
                if (commit)
                begin
                    if (c_kfc == CH_LC_E)
                    begin
                        exp_next = 1'b1;
                    end
                    if (c_kfc == CH_LC_C)
                    begin
                        if (c_klen == KEY_LEN_CONTENT_LENGTH)
                        begin
                            len_next = c_acc;
                        end
                        if (c_klen == KEY_LEN_CONNECTION)
                        begin
                            case ((c_vfc >= "A" && c_vfc <= "Z") ? c_vfc + 8'd32 : c_vfc)
                                CH_LC_C: ka_next  = KA_FALSE;
                                CH_LC_K: ka_next  = KA_TRUE;
                                CH_LC_T: tls_next = 1'b1;
                                CH_LC_U: upg_next = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                end
                if (end_head)
                begin
                    go    = 1'b1;
                    go_ph = (len_next != '0) ? PH_BODY : PH_DONE;
                    fe    = 1'b1;
                    cls   = BC_DELIM;
                end
            end
            PH_BODY:
            begin
                cls = BC_BODY;
            end
            default:
            begin
                cls = BC_SKIP;
            end
        endcase

        if (go)
        begin
            phase_next = go_ph;
            sub_next   = SS_ZERO;
            pos_next   = 4'd0;
        end
    end

    always_comb
    begin
        out_next.byte_class        = cls;
        out_next.out_byte          = ob;
        out_next.field_end         = fe;
        out_next.phase             = phase_next;
        out_next.method_code       = meth_next;
        out_next.version_code      = ver_next;
        out_next.content_length    = 32'(len_next);
        out_next.keep_alive        = ka_next;
        out_next.tls_requested     = tls_next;
        out_next.upgrade_requested = upg_next;
        out_next.expect_seen       = exp_next;
        out_next.error_code        = err_next;
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            out_reg <= out_next;
            if (pfx_we)
            begin
                pfx_reg[c_pos[PW-1:0]] <= b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_METHOD;
            sub_reg       <= SS_ZERO;
            pos_reg       <= 4'd0;
            meth_reg      <= 5'd0;
            ver_reg       <= 2'd0;
            kfc_reg       <= 8'd0;
            klen_reg      <= 5'd0;
            vfc_reg       <= 8'd0;
            acc_reg       <= '0;
            len_reg       <= '0;
            ka_reg        <= KA_NONE;
            err_reg       <= ERR_NONE;
            tls_reg       <= 1'b0;
            upg_reg       <= 1'b0;
            exp_reg       <= 1'b0;
            prev_reg      <= 8'd0;
        end
        else
        begin
            if (tok_pop)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                sub_reg       <= sub_next;
                pos_reg       <= pos_next;
                meth_reg      <= meth_next;
                ver_reg       <= ver_next;
                kfc_reg       <= kfc_next;
                klen_reg      <= klen_next;
                vfc_reg       <= vfc_next;
                acc_reg       <= acc_next;
                len_reg       <= len_next;
                ka_reg        <= ka_next;
                err_reg       <= err_next;
                tls_reg       <= tls_next;
                upg_reg       <= upg_next;
                exp_reg       <= exp_next;
                prev_reg      <= b;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/http_request_head_parser.sv]
// HTTP request head parser, one byte per transfer on each side.
// The req channel carries a received byte and start_request, which clears
// the parser to the method phase before that byte is taken. The res channel
// returns one result per byte: its class, the byte (lowercased inside header
// keys), a field end mark and the request summary as it stands after it.
// A byte is decoded on entry (lowercase, blank and digit flags) and written
// into a two-entry queue; the parser core takes one byte a cycle from the
// queue into its output register while that register is empty or the
// receiver is ready. A req byte passes the queue entry and then the output
// register on its way to its result.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more bytes before req.ready falls.
// Reset empties the queue and the output register and puts the parser in
// the method phase with every summary field at zero.
module http_request_head_parser import hrp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input logic      clk,
    input logic      rst_n,
    hrp_req_if.sink  req,
    hrp_res_if.source res
);

    tok_t in_tok;
    tok_t q_tok;
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    logic push;
    res_t result;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    hrp_front u_front
    (
        .data_byte     (req.data_byte),
        .start_request (req.start_request),
        .tok           (in_tok)
    );

    hrp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_tok),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_tok)
    );

    hrp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_not_empty),
        .tok       (q_tok),
        .tok_pop   (q_pop),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res       (result)
    );

    assign res.byte_class        = result.byte_class;
    assign res.out_byte          = result.out_byte;
    assign res.field_end         = result.field_end;
    assign res.phase             = result.phase;
    assign res.method_code       = result.method_code;
    assign res.version_code      = result.version_code;
    assign res.content_length    = result.content_length;
    assign res.keep_alive        = result.keep_alive;
    assign res.tls_requested     = result.tls_requested;
    assign res.upgrade_requested = result.upgrade_requested;
    assign res.expect_seen       = result.expect_seen;
    assign res.error_code        = result.error_code;

endmodule
